// ===== rtl/x86_16bit_instruction_decoder_macros.svh =====
// Assertion helpers for the decoder.
`ifndef X86_16BIT_INSTRUCTION_DECODER_MACROS_SVH
`define X86_16BIT_INSTRUCTION_DECODER_MACROS_SVH
// implication checked every clock outside reset
`define XD_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define XD_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/xdec_pkg.sv =====
`default_nettype none
package xdec_pkg;
  localparam logic [2:0] OP_MOV = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_CMP = 3'd3;
  localparam logic [2:0] OP_JMP = 3'd4;
  localparam logic [2:0] OP_REP = 3'd5;
  localparam logic [2:0] OP_UNK = 3'd6;

  localparam logic [2:0] FM_RMR = 3'd0;
  localparam logic [2:0] FM_IRM = 3'd1;
  localparam logic [2:0] FM_IRG = 3'd2;
  localparam logic [2:0] FM_ACC = 3'd3;
  localparam logic [2:0] FM_JMP = 3'd4;
  localparam logic [2:0] FM_PFX = 3'd5;

  // register-file action requested by the front end
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_IMM  = 2'd1;
  localparam logic [1:0] WR_MOVE = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  form;
    logic [2:0]  length;
    logic        wide;
    logic        direction;
    logic [1:0]  mode_field;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [4:0]  condition;
    logic [1:0]  wr_kind;
    logic [2:0]  dst;
    logic [2:0]  src;
  } dec_t;

  function automatic logic [15:0] sext8(input logic [7:0] x);
    return {{8{x[7]}}, x};
  endfunction
endpackage
`default_nettype wire

// ===== rtl/x86_16bit_instruction_decoder.sv =====
// Path: an accepted window is registered in a queue slot, then in the execute register.
// Throughput: one item per cycle while out_stall is low; front decode and queue sustain back-to-back items.
// The register-file read/merge/write in the back stage sets the feedback loop.
// Reset (rst_n low, synchronous): queue and output emptied, all 8 registers cleared.
`default_nettype none
module x86_16bit_instruction_decoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte0,
  input  wire logic [7:0]    in_byte1,
  input  wire logic [7:0]    in_byte2,
  input  wire logic [7:0]    in_byte3,
  input  wire logic [7:0]    in_byte4,
  input  wire logic [7:0]    in_byte5,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         out_operation,
  output logic [2:0]         out_form,
  output logic [2:0]         out_length,
  output logic               out_wide,
  output logic               out_direction,
  output logic [1:0]         out_mode_field,
  output logic [2:0]         out_reg_field,
  output logic [2:0]         out_rm_field,
  output logic signed [15:0] out_displacement,
  output logic signed [15:0] out_immediate,
  output logic [4:0]         out_condition,
  output logic [15:0]        out_written_value
);
  xdec_pkg::dec_t f_dec;
  xdec_pkg::dec_t q_dec;
  logic q_valid;
  logic q_stall;

  xdec_front u_front (
    .byte0(in_byte0), .byte1(in_byte1), .byte2(in_byte2),
    .byte3(in_byte3), .byte4(in_byte4), .byte5(in_byte5),
    .dec(f_dec)
  );

  xdec_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_dec(f_dec),
    .q_valid(q_valid), .q_stall(q_stall), .q_dec(q_dec)
  );

  xdec_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_dec(q_dec), .q_stall(q_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_operation(out_operation), .out_form(out_form), .out_length(out_length),
    .out_wide(out_wide), .out_direction(out_direction),
    .out_mode_field(out_mode_field), .out_reg_field(out_reg_field),
    .out_rm_field(out_rm_field), .out_displacement(out_displacement),
    .out_immediate(out_immediate), .out_condition(out_condition),
    .out_written_value(out_written_value)
  );
endmodule
`default_nettype wire

// ===== rtl/xdec_front.sv =====
`default_nettype none
module xdec_front (
  input  wire logic [7:0] byte0,
  input  wire logic [7:0] byte1,
  input  wire logic [7:0] byte2,
  input  wire logic [7:0] byte3,
  input  wire logic [7:0] byte4,
  input  wire logic [7:0] byte5,
  output xdec_pkg::dec_t  dec
);
  logic [1:0] md;
  logic [2:0] rg;
  logic [2:0] rmf;
  logic [1:0] dn;
  logic [15:0] dsp;
  logic [7:0] ib0;
  logic [7:0] ib1;
  logic is_mov;
  logic [2:0] gop;

  assign md  = byte1[7:6];
  assign rg  = byte1[5:3];
  assign rmf = byte1[2:0];

  // displacement bytes after modrm
  always_comb begin
    dn = 2'd0;
    dsp = 16'd0;
    if (md == 2'd1) begin
      dn = 2'd1;
      dsp = xdec_pkg::sext8(byte2);
    end else if (md == 2'd2 || (md == 2'd0 && rmf == 3'd6)) begin
      dn = 2'd2;
      dsp = {byte3, byte2};
    end
  end

  // immediate bytes located after displacement
  always_comb begin
    unique case (dn)
      2'd0: begin ib0 = byte2; ib1 = byte3; end
      2'd1: begin ib0 = byte3; ib1 = byte4; end
      default: begin ib0 = byte4; ib1 = byte5; end
    endcase
  end

  assign is_mov = (byte0[7:1] == 7'b1100011);

  always_comb begin
    if (is_mov) gop = (rg == 3'd0) ? xdec_pkg::OP_MOV : xdec_pkg::OP_UNK;
    else if (rg == 3'd0) gop = xdec_pkg::OP_ADD;
    else if (rg == 3'd5) gop = xdec_pkg::OP_SUB;
    else if (rg == 3'd7) gop = xdec_pkg::OP_CMP;
    else gop = xdec_pkg::OP_UNK;
  end

  // classify
  always_comb begin
    dec = '0;
    dec.operation = xdec_pkg::OP_UNK;
    dec.form = xdec_pkg::FM_RMR;
    dec.length = 3'd1;
    dec.wr_kind = xdec_pkg::WR_NONE;
    priority if (byte0 == 8'hF2 || byte0 == 8'hF3) begin
      dec.operation = xdec_pkg::OP_REP;
      dec.form = xdec_pkg::FM_PFX;
    end else if (byte0[7:4] == 4'b1011) begin
      dec.wide = byte0[3];
      dec.reg_field = byte0[2:0];
      dec.immediate = byte0[3] ? {byte2, byte1} : xdec_pkg::sext8(byte1);
      dec.operation = xdec_pkg::OP_MOV;
      dec.form = xdec_pkg::FM_IRG;
      dec.length = byte0[3] ? 3'd3 : 3'd2;
      dec.direction = 1'b1;
      dec.wr_kind = xdec_pkg::WR_IMM;
      dec.dst = byte0[2:0];
    end else if (byte0 == 8'h04 || byte0 == 8'h05 || byte0 == 8'h2C || byte0 == 8'h2D ||
                 byte0 == 8'h3C || byte0 == 8'h3D) begin
      dec.wide = byte0[0];
      dec.operation = (byte0 < 8'h10) ? xdec_pkg::OP_ADD :
                      (byte0 < 8'h30) ? xdec_pkg::OP_SUB : xdec_pkg::OP_CMP;
      dec.form = xdec_pkg::FM_ACC;
      dec.direction = 1'b1;
      dec.length = byte0[0] ? 3'd3 : 3'd2;
      dec.immediate = byte0[0] ? {byte2, byte1} : xdec_pkg::sext8(byte1);
    end else if (byte0[7:2] == 6'h28) begin
      dec.wide = byte0[0];
      dec.operation = xdec_pkg::OP_MOV;
      dec.form = xdec_pkg::FM_ACC;
      dec.length = 3'd3;
      dec.direction = ~byte0[1];
      dec.displacement = {byte2, byte1};
    end else if (byte0[7:2] == 6'h22 || byte0[7:2] == 6'h00 ||
                 byte0[7:2] == 6'h0A || byte0[7:2] == 6'h0E) begin
      dec.operation = (byte0[7:2] == 6'h22) ? xdec_pkg::OP_MOV :
                      (byte0[7:2] == 6'h00) ? xdec_pkg::OP_ADD :
                      (byte0[7:2] == 6'h0A) ? xdec_pkg::OP_SUB : xdec_pkg::OP_CMP;
      dec.direction = byte0[1];
      dec.wide = byte0[0];
      dec.mode_field = md;
      dec.reg_field = rg;
      dec.rm_field = rmf;
      dec.displacement = dsp;
      dec.length = 3'd2 + {1'b0, dn};
      if (byte0[7:2] == 6'h22 && md == 2'd3) begin
        dec.wr_kind = xdec_pkg::WR_MOVE;
        dec.dst = byte0[1] ? rg : rmf;
        dec.src = byte0[1] ? rmf : rg;
      end
    end else if (is_mov || byte0[7:2] == 6'h20) begin
      if (gop != xdec_pkg::OP_UNK) begin
        dec.operation = gop;
        dec.form = xdec_pkg::FM_IRM;
        dec.wide = byte0[0];
        dec.mode_field = md;
        dec.reg_field = rg;
        dec.rm_field = rmf;
        dec.displacement = dsp;
        if (byte0[0] && (is_mov || byte0 == 8'h81)) begin
          dec.immediate = (dn == 2'd2) ? {byte5, byte4} : {ib1, ib0};
          dec.length = 3'd4 + {1'b0, dn};
        end else begin
          dec.immediate = xdec_pkg::sext8(ib0);
          dec.length = 3'd3 + {1'b0, dn};
        end
        if (is_mov && md == 2'd3) begin
          dec.wr_kind = xdec_pkg::WR_IMM;
          dec.dst = rmf;
        end
      end
    end else if (byte0[7:4] == 4'h7 || byte0[7:2] == 6'b111000) begin
      dec.operation = xdec_pkg::OP_JMP;
      dec.form = xdec_pkg::FM_JMP;
      dec.length = 3'd2;
      dec.displacement = xdec_pkg::sext8(byte1);
      dec.condition = (byte0[7:4] == 4'h7) ? {1'b0, byte0[3:0]} : {3'b100, byte0[1:0]};
    end else begin
      dec.operation = xdec_pkg::OP_UNK;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/xdec_back.sv =====
`default_nettype none
`include "x86_16bit_instruction_decoder_macros.svh"
module xdec_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  xdec_pkg::dec_t      q_dec,
  output logic                q_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [2:0]          out_operation,
  output logic [2:0]          out_form,
  output logic [2:0]          out_length,
  output logic                out_wide,
  output logic                out_direction,
  output logic [1:0]          out_mode_field,
  output logic [2:0]          out_reg_field,
  output logic [2:0]          out_rm_field,
  output logic signed [15:0]  out_displacement,
  output logic signed [15:0]  out_immediate,
  output logic [4:0]          out_condition,
  output logic [15:0]         out_written_value
);
  logic [15:0] rf_r [8];
  logic        vld_r;
  xdec_pkg::dec_t d_r;
  logic [15:0] wv_r;
  logic        take;
  logic [15:0] srcv;
  logic [15:0] val;
  logic [15:0] wv_nxt;
  logic [2:0]  widx;
  logic        wen;

  assign q_stall = vld_r && out_stall;
  assign take = q_valid && !q_stall;

  // source value for the write
  always_comb begin
    if (q_dec.wide) srcv = rf_r[q_dec.src];
    else if (!q_dec.src[2]) srcv = {8'd0, rf_r[q_dec.src][7:0]};
    else srcv = {8'd0, rf_r[{1'b0, q_dec.src[1:0]}][15:8]};
    val = (q_dec.wr_kind == xdec_pkg::WR_MOVE) ? srcv : q_dec.immediate;
  end

  // merged entry content
  always_comb begin
    wen = take && (q_dec.wr_kind != xdec_pkg::WR_NONE);
    widx = q_dec.wide ? q_dec.dst : {1'b0, q_dec.dst[1:0]};
    if (q_dec.wide) wv_nxt = val;
    else if (!q_dec.dst[2]) wv_nxt = {rf_r[widx][15:8], val[7:0]};
    else wv_nxt = {val[7:0], rf_r[widx][7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= 16'd0;
    end else begin
      if (wen) rf_r[widx] <= wv_nxt;
      if (take) vld_r <= 1'b1;
      else if (!out_stall) vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      d_r <= q_dec;
      wv_r <= (q_dec.wr_kind != xdec_pkg::WR_NONE) ? wv_nxt : 16'd0;
    end
  end

  assign out_valid = vld_r;
  assign out_operation = d_r.operation;
  assign out_form = d_r.form;
  assign out_length = d_r.length;
  assign out_wide = d_r.wide;
  assign out_direction = d_r.direction;
  assign out_mode_field = d_r.mode_field;
  assign out_reg_field = d_r.reg_field;
  assign out_rm_field = d_r.rm_field;
  assign out_displacement = d_r.displacement;
  assign out_immediate = d_r.immediate;
  assign out_condition = d_r.condition;
  assign out_written_value = wv_r;

  `XD_ASSERT_NXT(a_take_valid, clk, rst_n, take, vld_r)
  `XD_ASSERT_NXT(a_hold, clk, rst_n, vld_r && out_stall, vld_r && $stable(wv_r))
  `XD_ASSERT_IMP(a_wv_zero, clk, rst_n, vld_r && d_r.operation != xdec_pkg::OP_MOV,
                 wv_r == 16'd0)
endmodule
`default_nettype wire

// ===== rtl/xdec_queue.sv =====
`default_nettype none
module xdec_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  xdec_pkg::dec_t in_dec,
  output logic           q_valid,
  input  wire logic      q_stall,
  output xdec_pkg::dec_t q_dec
);
  // two-entry queue: main slot plus skid slot
  logic vm_r;
  logic vs_r;
  xdec_pkg::dec_t m_r;
  xdec_pkg::dec_t s_r;
  logic push;
  logic pop;

  assign in_stall = vs_r;
  assign push = in_valid && !vs_r;
  assign pop = vm_r && !q_stall;
  assign q_valid = vm_r;
  assign q_dec = m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vs_r <= 1'b0;
    end else begin
      if (pop) begin
        vm_r <= vs_r || push;
        vs_r <= 1'b0;
      end else if (push) begin
        if (vm_r) vs_r <= 1'b1;
        else vm_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) m_r <= vs_r ? s_r : in_dec;
    else if (push && !vm_r) m_r <= in_dec;
    if (push && vm_r && !pop) s_r <= in_dec;
  end
endmodule
`default_nettype wire
